/* sv/fpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the binary32 add/sub/mul/div unit
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  // classified transaction handed from the front end to the back end
  typedef struct packed {
    op_e         op;
    logic [31:0] a;
    logic [31:0] b;
    logic        special;
    logic [31:0] spec_val;
    logic        dz;
  } fe_item_t;

endpackage
`default_nettype wire

/* sv/fpa_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front
// accepts transactions, resolves special operands and registers them
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             f_valid,
  output fe_item_t         f_item,
  input  wire logic        f_ready
);

  fe_item_t item_next;
  logic     accept;

  always_comb begin
    logic [31:0] a;
    logic [31:0] b;
    logic        na, nb, ia, ib, za, zb, sgn;
    a = operand_a;
    b = operand_b;
    if (op_e'(req_type) == OP_SUB) begin
      b = {~operand_b[31], operand_b[30:0]};
    end
    na  = a[30:0] > INF_BITS[30:0];
    nb  = b[30:0] > INF_BITS[30:0];
    ia  = a[30:0] == INF_BITS[30:0];
    ib  = b[30:0] == INF_BITS[30:0];
    za  = a[30:0] == 31'd0;
    zb  = b[30:0] == 31'd0;
    sgn = a[31] ^ b[31];
    item_next.op       = (op_e'(req_type) == OP_SUB) ? OP_ADD : op_e'(req_type);
    item_next.a        = a;
    item_next.b        = b;
    item_next.special  = 1'b0;
    item_next.spec_val = 32'd0;
    item_next.dz       = 1'b0;
    unique case (op_e'(req_type))
      OP_ADD, OP_SUB: begin
        if (na || nb) begin
          item_next.special = 1'b1;
          item_next.spec_val = QNAN_BITS;
        end else if (ia) begin
          item_next.special = 1'b1;
          item_next.spec_val = (ib && (a[31] != b[31])) ? QNAN_BITS : a;
        end else if (ib) begin
          item_next.special = 1'b1;
          item_next.spec_val = b;
        end
      end
      OP_MUL: begin
        if (na || nb) begin
          item_next.special = 1'b1;
          item_next.spec_val = QNAN_BITS;
        end else if (ia || ib) begin
          item_next.special = 1'b1;
          item_next.spec_val = (za || zb) ? QNAN_BITS : {sgn, INF_BITS[30:0]};
        end else if (za || zb) begin
          item_next.special = 1'b1;
          item_next.spec_val = {sgn, 31'd0};
        end
      end
      OP_DIV: begin
        if (zb) begin
          item_next.special = 1'b1;
          item_next.spec_val = 32'd0;
          item_next.dz = 1'b1;
        end else if (na || nb) begin
          item_next.special = 1'b1;
          item_next.spec_val = QNAN_BITS;
        end else if (ia) begin
          item_next.special = 1'b1;
          item_next.spec_val = ib ? QNAN_BITS : {sgn, INF_BITS[30:0]};
        end else if (ib || za) begin
          item_next.special = 1'b1;
          item_next.spec_val = {sgn, 31'd0};
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall = f_valid && !f_ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_item <= item_next;
    end
  end

endmodule
`default_nettype wire

/* sv/fpa_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_queue
// two-entry queue between the front end and the back end
// ----------------------------------------------------------------------------
module fpa_queue import fpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic f_valid,
  input  fe_item_t  f_item,
  output logic      f_ready,
  output logic      q_valid,
  output fe_item_t  q_item,
  input  wire logic q_pop
);

  fe_item_t   mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign q_valid = count != 2'd0;
  assign q_item  = mem[rd_ptr];
  assign f_ready = (count != 2'd2) || q_pop;
  assign push    = f_valid && f_ready;
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wr_ptr] <= f_item;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_pop) |-> !f_ready)
    else $error("push into full queue");

endmodule
`default_nettype wire

/* sv/fpa_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_back
// execution pipeline: align/multiply/divide steps, normalize, round
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  fe_item_t         q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result_value,
  output logic             divide_by_zero
);

  localparam int NST = 15;

  typedef struct packed {
    logic               valid;
    logic               special;
    logic [31:0]        spec_val;
    logic               dz;
    op_e                op;
    logic               sign;
    logic               sb;
    logic signed [10:0] e;
    logic [62:0]        m;
    logic [62:0]        m2;
    logic [24:0]        r;
    logic [23:0]        dsor;
    logic [40:0]        q;
    logic [5:0]         lz;
  } bs_t;

  bs_t  st [0:NST-1];
  bs_t  nx [0:NST-1];
  logic en;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc63(input logic [62:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd63;
    found = 1'b0;
    for (int i = 62; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 6'(62 - i);
      end
    end
    return n;
  endfunction

  assign en    = !out_valid || !out_stall;
  assign q_pop = q_valid && en;

  // unpack, align, multiply, pre-normalize divide operands
  always_comb begin
    logic signed [10:0] ea, eb, d;
    logic [23:0]        siga, sigb, sbig, ssml;
    logic [63:0]        mb64, lost;
    logic [4:0]         la, lb;
    logic               swap;
    ea   = (q_item.a[30:23] == 8'd0) ? -11'sd149 : $signed({3'b0, q_item.a[30:23]}) - 11'sd150;
    eb   = (q_item.b[30:23] == 8'd0) ? -11'sd149 : $signed({3'b0, q_item.b[30:23]}) - 11'sd150;
    siga = {q_item.a[30:23] != 8'd0, q_item.a[22:0]};
    sigb = {q_item.b[30:23] != 8'd0, q_item.b[22:0]};
    swap = ea < eb;
    sbig = swap ? sigb : siga;
    ssml = swap ? siga : sigb;
    d    = swap ? (eb - ea) : (ea - eb);
    mb64 = {10'd0, ssml, 30'd0};
    lost = mb64 & ((64'd1 << d[5:0]) - 64'd1);
    la   = lzc24(siga);
    lb   = lzc24(sigb);
    nx[0]          = '0;
    nx[0].valid    = q_pop;
    nx[0].special  = q_item.special;
    nx[0].spec_val = q_item.spec_val;
    nx[0].dz       = q_item.dz;
    nx[0].op       = q_item.op;
    nx[0].sign     = q_item.a[31] ^ q_item.b[31];
    unique case (q_item.op)
      OP_ADD, OP_SUB: begin
        nx[0].sign = swap ? q_item.b[31] : q_item.a[31];
        nx[0].sb   = swap ? q_item.a[31] : q_item.b[31];
        nx[0].e    = (swap ? eb : ea) - 11'sd30;
        nx[0].m    = {9'd0, sbig, 30'd0};
        if (d > 11'sd62) begin
          nx[0].m2 = {62'd0, ssml != 24'd0};
        end else begin
          nx[0].m2 = 63'((mb64 >> d[5:0]) | {63'd0, lost != 64'd0});
        end
      end
      OP_MUL: begin
        nx[0].e = ea + eb;
        nx[0].m = {15'd0, {24'd0, siga} * {24'd0, sigb}};
      end
      OP_DIV: begin
        nx[0].r    = {1'b0, siga << la};
        nx[0].dsor = sigb << lb;
        nx[0].e    = (ea - $signed({6'd0, la})) - 11'sd40 - (eb - $signed({6'd0, lb}));
      end
      default: begin
      end
    endcase
  end

  // add/sub combine in the first step, four quotient bits per step (one in the last)
  for (genvar k = 1; k <= 11; k++) begin : g_div
    always_comb begin
      bs_t s;
      s = st[k-1];
      if (k == 1 && (s.op == OP_ADD || s.op == OP_SUB)) begin
        if (s.sign == s.sb) begin
          s.m = s.m + s.m2;
        end else if (s.m >= s.m2) begin
          s.m = s.m - s.m2;
          if (s.m == 63'd0) begin
            s.sign = 1'b0;
          end
        end else begin
          s.m = s.m2 - s.m;
          s.sign = s.sb;
        end
      end
      if (s.op == OP_DIV) begin
        for (int j = 0; j < 4; j++) begin
          if (4 * (k - 1) + j <= 40) begin
            if (s.r >= {1'b0, s.dsor}) begin
              s.q[40 - (4 * (k - 1) + j)] = 1'b1;
              s.r = s.r - {1'b0, s.dsor};
            end
            s.r = s.r << 1;
          end
        end
      end
      nx[k] = s;
    end
  end

  // quotient with sticky
  always_comb begin
    nx[12] = st[11];
    if (st[11].op == OP_DIV) begin
      nx[12].m = {22'd0, st[11].q[40:1], st[11].q[0] | (st[11].r != 25'd0)};
    end
  end

  // leading zero count
  always_comb begin
    nx[13]    = st[12];
    nx[13].lz = lzc63(st[12].m);
  end

  // normalize
  always_comb begin
    nx[14]   = st[13];
    nx[14].m = st[13].m << st[13].lz;
    nx[14].e = st[13].e - $signed({5'd0, st[13].lz});
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (rst) begin
        st[i].valid <= 1'b0;
      end else if (en) begin
        st[i] <= nx[i];
      end
    end
  end

  // round to nearest even and pack
  logic [31:0] res_next;

  always_comb begin
    logic signed [10:0] bexp;
    logic [10:0]        shw;
    logic [5:0]         sh;
    logic [63:0]        m64, sig, rem, half;
    logic [7:0]         field;
    bs_t                s;
    s     = st[14];
    bexp  = s.e + 11'sd189;
    shw   = (bexp >= 11'sd1) ? 11'd39 : (11'd40 - bexp);
    sh    = shw[5:0];
    m64   = {1'b0, s.m};
    sig   = m64 >> sh;
    rem   = m64 & ((64'd1 << sh) - 64'd1);
    half  = 64'd1 << (sh - 6'd1);
    field = (bexp >= 11'sd1) ? 8'(bexp - 11'sd1) : 8'd0;
    if (rem > half || (rem == half && sig[0])) begin
      sig = sig + 64'd1;
    end
    if (s.special) begin
      res_next = s.spec_val;
    end else if (s.m == 63'd0) begin
      res_next = {s.sign, 31'd0};
    end else if (bexp >= 11'sd255) begin
      res_next = {s.sign, INF_BITS[30:0]};
    end else if (bexp < -11'sd23) begin
      res_next = {s.sign, 31'd0};
    end else begin
      res_next = {s.sign, 31'd0} + ({1'b0, field, 23'd0} + sig[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st[14].valid;
    end
    if (en) begin
      result_value   <= res_next;
      divide_by_zero <= st[14].dz;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (result_value == 32'd0))
    else $error("divide by zero result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (st[14] === $past(st[14])))
    else $error("pipeline moved under stall");
  a_dz_div: assert property (@(posedge clk) disable iff (rst)
    (st[14].valid && st[14].dz) |-> (st[14].op == OP_DIV))
    else $error("divide by zero flag on non-divide");

endmodule
`default_nettype wire

/* sv/float_four_op_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// float_four_op_alu
// binary32 add, subtract, multiply and divide with round to nearest even
// ----------------------------------------------------------------------------
// One transaction per clock is accepted and one result per clock delivered
// while out_stall is low. The front register that resolves special operands
// is loaded at the accepting edge; the item then passes through the two-entry
// queue, fifteen back-end stages (eleven of which carry the radix-16 restoring
// divider) and the output register. Division by either zero returns +0 with
// divide_by_zero set; all NaN results are 0x7FC00000.
module float_four_op_alu import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result_value,
  output logic             divide_by_zero
);

  fe_item_t f_item;
  fe_item_t q_item;
  logic     f_valid;
  logic     f_ready;
  logic     q_valid;
  logic     q_pop;

  fpa_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .operand_a, .operand_b,
    .f_valid, .f_item, .f_ready
  );

  fpa_queue u_queue (
    .clk, .rst, .f_valid, .f_item, .f_ready, .q_valid, .q_item, .q_pop
  );

  fpa_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .out_valid, .out_stall,
    .result_value, .divide_by_zero
  );

endmodule
`default_nettype wire
